[hdl/lscn_pkg.sv]
// Shared types and constants for the line sensor calibrate/normalize unit.
package lscn_pkg;

  localparam int CHAN_W      = 4;
  localparam int ADC_W       = 8;
  localparam int NIBBLE_W    = 4;
  localparam int READ_W      = 12;
  localparam int LEVEL_W     = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BLACK = 2'd1,
    CMD_WHITE = 2'd2,
    CMD_NORM  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } back_state_e;

  // Decoded item handed from the front end to the back end.
  typedef struct packed {
    cmd_e                cmd;
    logic [CHAN_W-1:0]   channel;
    logic [READ_W-1:0]   reading;
    logic                chan_ok;
  } work_t;

  // One finished result transaction.
  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [READ_W-1:0]  reading;
    logic [LEVEL_W-1:0] level;
    logic [READ_W-1:0]  black_level;
    logic [READ_W-1:0]  white_level;
    logic               degenerate;
  } result_t;

endpackage

[hdl/line_sensor_calibrate_normalize_unit.sv]
// Top level of the line sensor min/max calibration and normalize unit.
//
//   channel  dir  handshake        payload
//   -------  ---  ---------------  ------------------------------------------------
//   input    in   push / full      command_i, channel_i, adc_high_i, adc_low_i
//   result   out  empty / pop      out_channel_o, reading_o, level_o,
//                                  black_level_o, white_level_o, degenerate_o
//
// Sequencing: clear and sample transactions pass through the back end without the divider;
// a normalize that needs a real division waits on the bit-serial divider, which produces
// one quotient bit per cycle.
// Reset: asynchronous, active low; clears queues, result slot and calibration valid
// bits, so every channel's black and white maxima read as zero.
// Stalls: a two-entry queue decouples input from the back end, and the result slot
// lets the back end finish the next transaction while a result waits for pop.
module line_sensor_calibrate_normalize_unit #(
  parameter int CHANNELS      = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input queue side
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   command_i,
  input  logic [lscn_pkg::CHAN_W-1:0]  channel_i,
  input  logic [lscn_pkg::ADC_W-1:0]   adc_high_i,
  input  logic [lscn_pkg::ADC_W-1:0]   adc_low_i,
  // result queue side
  output logic                         empty,
  input  logic                         pop,
  output logic [lscn_pkg::CHAN_W-1:0]  out_channel_o,
  output logic [lscn_pkg::READ_W-1:0]  reading_o,
  output logic [lscn_pkg::LEVEL_W-1:0] level_o,
  output logic [lscn_pkg::READ_W-1:0]  black_level_o,
  output logic [lscn_pkg::READ_W-1:0]  white_level_o,
  output logic                         degenerate_o
);

  // Front to back hand-off of decoded transactions.
  logic              wk_valid, wk_ready;
  lscn_pkg::work_t   wk;

  // Result slot.
  logic              res_valid;
  lscn_pkg::result_t res;

  lscn_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .command_i (command_i),
    .channel_i (channel_i),
    .adc_high_i(adc_high_i),
    .adc_low_i (adc_low_i),
    .wk_valid_o(wk_valid),
    .wk_ready_i(wk_ready),
    .wk_o      (wk)
  );

  lscn_back #(
    .CHANNELS     (CHANNELS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wk_valid_i (wk_valid),
    .wk_ready_o (wk_ready),
    .wk_i       (wk),
    .res_valid_o(res_valid),
    .res_pop_i  (pop && !empty),
    .res_o      (res)
  );

  // The oldest result is shown while empty is low.
  assign empty         = !res_valid;
  assign out_channel_o = res.out_channel;
  assign reading_o     = res.reading;
  assign level_o       = res.level;
  assign black_level_o = res.black_level;
  assign white_level_o = res.white_level;
  assign degenerate_o  = res.degenerate;

endmodule

[hdl/lscn_front.sv]
// Front end: accepts input transactions, decodes them and queues them for the back end.
module lscn_front #(
  parameter int CHANNELS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  command_i,
  input  logic [lscn_pkg::CHAN_W-1:0] channel_i,
  input  logic [lscn_pkg::ADC_W-1:0]  adc_high_i,
  input  logic [lscn_pkg::ADC_W-1:0]  adc_low_i,
  output logic                        wk_valid_o,
  input  logic                        wk_ready_i,
  output lscn_pkg::work_t             wk_o
);

  lscn_pkg::work_t                   fifo_q [lscn_pkg::QUEUE_DEPTH];
  logic [lscn_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [lscn_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [lscn_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  lscn_pkg::work_t                   dec;
  logic                              do_push, do_pop;

  // Decode: reading is the low nibble of the first byte over the second byte.
  always_comb begin
    dec.cmd     = lscn_pkg::cmd_e'(command_i);
    dec.channel = channel_i;
    dec.reading = {adc_high_i[lscn_pkg::NIBBLE_W-1:0], adc_low_i};
    dec.chan_ok = (32'(channel_i) < 32'(CHANNELS));
  end

  assign full       = (cnt_q == lscn_pkg::QCNT_W'(lscn_pkg::QUEUE_DEPTH));
  assign wk_valid_o = (cnt_q != '0);
  assign wk_o       = fifo_q[rd_ptr_q];
  assign do_push    = push && !full;
  assign do_pop     = wk_valid_o && wk_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == lscn_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == lscn_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

endmodule

[hdl/lscn_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, numerator below denominator.
module lscn_div #(
  parameter int FRAC_W = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lscn_pkg::READ_W-1:0] num_i,
  input  logic [lscn_pkg::READ_W-1:0] den_i,
  output logic                        done_o,
  output logic [FRAC_W-1:0]           quot_o
);

  localparam int CntW = $clog2(FRAC_W);

  logic                        busy_q, done_q;
  logic [CntW-1:0]             cnt_q;
  logic [lscn_pkg::READ_W-1:0] rem_q, rem_d, den_q;
  logic [FRAC_W-1:0]           quot_q;
  logic [lscn_pkg::READ_W:0]   rem2;
  logic                        ge;

  // Remainder stays below den, so the doubled value fits one extra bit.
  assign rem2  = {rem_q, 1'b0};
  assign ge    = (rem2 >= {1'b0, den_q});
  assign rem_d = ge ? lscn_pkg::READ_W'(rem2 - {1'b0, den_q})
                    : lscn_pkg::READ_W'(rem2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(FRAC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRAC_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/lscn_back.sv]
// Back end: calibration stores, update/normalize sequencer and result register.
module lscn_back #(
  parameter int CHANNELS      = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wk_valid_i,
  output logic                wk_ready_o,
  input  lscn_pkg::work_t     wk_i,
  output logic                res_valid_o,
  input  logic                res_pop_i,
  output lscn_pkg::result_t   res_o
);

  localparam int IdxW   = $clog2(CHANNELS);
  localparam int LevelW = lscn_pkg::LEVEL_W;
  localparam int LvW    = FRACTION_BITS + 1;
  localparam int RdW    = lscn_pkg::READ_W;

  lscn_pkg::back_state_e state_q, state_d;

  // Calibration maxima; an entry whose valid bit is clear reads as zero.
  logic [RdW-1:0]      mem_black [CHANNELS];
  logic [RdW-1:0]      mem_white [CHANNELS];
  logic [CHANNELS-1:0] vld_black_q, vld_white_q;

  lscn_pkg::work_t     cur_q;
  logic [IdxW-1:0]     wk_idx, cur_idx;
  logic [RdW-1:0]      rd_black_q, rd_white_q;
  logic                rv_black_q, rv_white_q;
  logic [RdW-1:0]      blk_old, wht_old, blk_new, wht_new;
  logic [RdW-1:0]      blk_q, wht_q;
  logic                wr_black, wr_white, clr_all;
  logic                degen, need_div, degen_q;
  logic [LvW-1:0]      level_now, level_q;
  logic                div_start, div_done;
  logic [FRACTION_BITS-1:0] quot;
  logic                res_valid_q;
  lscn_pkg::result_t   res_q;
  logic                slot_free, res_load;

  assign wk_idx  = IdxW'(wk_i.channel);
  assign cur_idx = IdxW'(cur_q.channel);

  // Registered store read at pop time, used in the execute cycle.
  always_ff @(posedge clk_i) begin
    if (wk_ready_o && wk_valid_i) begin
      cur_q      <= wk_i;
      rd_black_q <= mem_black[wk_idx];
      rd_white_q <= mem_white[wk_idx];
      rv_black_q <= vld_black_q[wk_idx];
      rv_white_q <= vld_white_q[wk_idx];
    end
  end

  assign blk_old = (cur_q.chan_ok && rv_black_q) ? rd_black_q : '0;
  assign wht_old = (cur_q.chan_ok && rv_white_q) ? rd_white_q : '0;

  // Execute: update or clear the maxima and classify the normalize case.
  always_comb begin
    blk_new  = blk_old;
    wht_new  = wht_old;
    wr_black = 1'b0;
    wr_white = 1'b0;
    clr_all  = 1'b0;
    case (cur_q.cmd)
      lscn_pkg::CMD_CLEAR: begin
        clr_all = 1'b1;
        blk_new = '0;
        wht_new = '0;
      end
      lscn_pkg::CMD_BLACK: begin
        if (cur_q.chan_ok && cur_q.reading > blk_old) begin
          wr_black = 1'b1;
          blk_new  = cur_q.reading;
        end
      end
      lscn_pkg::CMD_WHITE: begin
        if (cur_q.chan_ok && cur_q.reading > wht_old) begin
          wr_white = 1'b1;
          wht_new  = cur_q.reading;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    degen     = 1'b0;
    need_div  = 1'b0;
    level_now = '0;
    if (cur_q.cmd == lscn_pkg::CMD_NORM) begin
      if (wht_new <= blk_new) begin
        degen     = 1'b1;
        level_now = (cur_q.reading > blk_new) ? {1'b1, {FRACTION_BITS{1'b0}}} : '0;
      end else if (cur_q.reading <= blk_new) begin
        level_now = '0;
      end else if (cur_q.reading >= wht_new) begin
        level_now = {1'b1, {FRACTION_BITS{1'b0}}};
      end else begin
        need_div = 1'b1;
      end
    end
  end

  lscn_div #(
    .FRAC_W(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (cur_q.reading - blk_new),
    .den_i  (wht_new - blk_new),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lscn_pkg::ST_IDLE: begin
        if (wk_valid_i) begin
          state_d = lscn_pkg::ST_EXEC;
        end
      end
      lscn_pkg::ST_EXEC: begin
        state_d = need_div ? lscn_pkg::ST_DIV : lscn_pkg::ST_DONE;
      end
      lscn_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lscn_pkg::ST_DONE;
        end
      end
      lscn_pkg::ST_DONE: begin
        if (slot_free) begin
          state_d = lscn_pkg::ST_IDLE;
        end
      end
      default: state_d = lscn_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  assign slot_free = !res_valid_q || res_pop_i;
  always_comb begin
    wk_ready_o = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    case (state_q)
      lscn_pkg::ST_IDLE: wk_ready_o = 1'b1;
      lscn_pkg::ST_EXEC: div_start  = need_div;
      lscn_pkg::ST_DONE: res_load   = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lscn_pkg::ST_IDLE;
      vld_black_q <= '0;
      vld_white_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lscn_pkg::ST_EXEC) begin
        if (clr_all) begin
          vld_black_q <= '0;
          vld_white_q <= '0;
        end
        if (wr_black) begin
          vld_black_q[cur_idx] <= 1'b1;
        end
        if (wr_white) begin
          vld_white_q[cur_idx] <= 1'b1;
        end
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lscn_pkg::ST_EXEC) begin
      if (wr_black) begin
        mem_black[cur_idx] <= cur_q.reading;
      end
      if (wr_white) begin
        mem_white[cur_idx] <= cur_q.reading;
      end
    end
  end

  // Working result fields.
  always_ff @(posedge clk_i) begin
    if (state_q == lscn_pkg::ST_EXEC) begin
      blk_q   <= blk_new;
      wht_q   <= wht_new;
      degen_q <= degen;
      level_q <= level_now;
    end else if (state_q == lscn_pkg::ST_DIV && div_done) begin
      level_q <= {1'b0, quot};
    end
    if (res_load) begin
      res_q.out_channel <= cur_q.channel;
      res_q.reading     <= cur_q.reading;
      res_q.level       <= LevelW'(level_q);
      res_q.black_level <= blk_q;
      res_q.white_level <= wht_q;
      res_q.degenerate  <= degen_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hdl/lscn_checker.sv]
// Port-level checker for the calibrate/normalize unit, with its bind.
module lscn_checker #(
  parameter int FRACTION_BITS = 15
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         empty,
  input logic                         pop,
  input logic [lscn_pkg::READ_W-1:0]  reading_o,
  input logic [lscn_pkg::LEVEL_W-1:0] level_o,
  input logic [lscn_pkg::READ_W-1:0]  black_level_o,
  input logic [lscn_pkg::READ_W-1:0]  white_level_o,
  input logic                         degenerate_o
);

  localparam logic [lscn_pkg::LEVEL_W-1:0] LevelOne =
    lscn_pkg::LEVEL_W'(1 << FRACTION_BITS);

  // Once reset has been seen at an edge, no result is offered at the next one.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered right after reset");

  // Degenerate calibration only yields zero or full scale.
  a_degen_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && degenerate_o) |-> (level_o == '0 || level_o == LevelOne))
    else $error("degenerate result with fractional level");

  // A degenerate result reports a white maximum no higher than the black maximum.
  a_degen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && degenerate_o) |-> (white_level_o <= black_level_o))
    else $error("degenerate flagged with white above black");

  // A nonzero level needs a reading above the black maximum.
  a_level_above_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && level_o != '0) |-> (reading_o > black_level_o))
    else $error("nonzero level at or below black");

  // A result not taken stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(level_o) && $stable(reading_o)))
    else $error("waiting result changed");

endmodule

bind line_sensor_calibrate_normalize_unit lscn_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_lscn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .reading_o    (reading_o),
  .level_o      (level_o),
  .black_level_o(black_level_o),
  .white_level_o(white_level_o),
  .degenerate_o (degenerate_o)
);

[bench/tb_top.sv]
// Self-checking bench for the line sensor calibrate/normalize unit: directed and random traffic, scoreboard.
module tb_top;
  import lscn_pkg::*;

  localparam int CHANNELS      = 16;
  localparam int FRACTION_BITS = 15;
  localparam int RANDOM_ITEMS  = 900;
  // Slowest legal run: ~925 items, each with the longest send gap, a full divide and the
  // longest pop stall. The limit allows several times that.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 64;

  // Predicts each result from its own copy of the black/white maxima and keeps the
  // predictions in arrival order until the matching result transaction pops out.
  class calib_scoreboard;
    logic [READ_W-1:0] cal_black[CHANNELS];
    logic [READ_W-1:0] cal_white[CHANNELS];
    result_t           pending_results[$];
    int                mismatches;
    int                results_checked;
    int                norm_count;
    int                degen_count;

    function new();
      foreach (cal_black[i]) begin
        cal_black[i] = '0;
        cal_white[i] = '0;
      end
      mismatches      = 0;
      results_checked = 0;
      norm_count      = 0;
      degen_count     = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Apply one accepted input transaction and queue the result it must produce.
    function void note_input(cmd_e cmd, logic [CHAN_W-1:0] ch,
                             logic [ADC_W-1:0] hi, logic [ADC_W-1:0] lo);
      result_t           r;
      logic [READ_W-1:0] rd;
      logic [READ_W-1:0] blk;
      logic [READ_W-1:0] wht;
      logic [63:0]       full_scale;
      logic [63:0]       num;
      bit                has_store;

      rd         = {hi[NIBBLE_W-1:0], lo};
      has_store  = (int'(ch) < CHANNELS);
      full_scale = 64'd1 << FRACTION_BITS;

      case (cmd)
        CMD_CLEAR: begin
          foreach (cal_black[i]) begin
            cal_black[i] = '0;
            cal_white[i] = '0;
          end
        end
        CMD_BLACK: if (has_store && rd > cal_black[ch]) cal_black[ch] = rd;
        CMD_WHITE: if (has_store && rd > cal_white[ch]) cal_white[ch] = rd;
        default: ;
      endcase

      blk = has_store ? cal_black[ch] : '0;
      wht = has_store ? cal_white[ch] : '0;

      r             = '0;
      r.out_channel = ch;
      r.reading     = rd;
      r.black_level = blk;
      r.white_level = wht;

      if (cmd == CMD_NORM) begin
        norm_count++;
        if (wht <= blk) begin
          // no usable span: a step function around the black level
          r.degenerate = 1'b1;
          r.level      = (rd > blk) ? LEVEL_W'(full_scale) : '0;
          degen_count++;
        end else if (rd <= blk) begin
          r.level = '0;
        end else if (rd >= wht) begin
          r.level = LEVEL_W'(full_scale);
        end else begin
          num     = (64'(rd) - 64'(blk)) << FRACTION_BITS;
          r.level = LEVEL_W'(num / (64'(wht) - 64'(blk)));
        end
      end

      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        mismatches++;
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    // Compare one popped result transaction with the oldest prediction.
    function void check_result(result_t got);
      result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: expected none, actual %p", $time, got);
        return;
      end
      exp_r = pending_results.pop_front();
      results_checked++;
      cmp_field("out_channel", exp_r.out_channel, got.out_channel);
      cmp_field("reading",     exp_r.reading,     got.reading);
      cmp_field("level",       exp_r.level,       got.level);
      cmp_field("black_level", exp_r.black_level, got.black_level);
      cmp_field("white_level", exp_r.white_level, got.white_level);
      cmp_field("degenerate",  exp_r.degenerate,  got.degenerate);
    endfunction
  endclass

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push   = 1'b0;
  logic                full;
  logic [1:0]          command_i  = CMD_CLEAR;
  logic [CHAN_W-1:0]   channel_i  = '0;
  logic [ADC_W-1:0]    adc_high_i = '0;
  logic [ADC_W-1:0]    adc_low_i  = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [CHAN_W-1:0]   out_channel_o;
  logic [READ_W-1:0]   reading_o;
  logic [LEVEL_W-1:0]  level_o;
  logic [READ_W-1:0]   black_level_o;
  logic [READ_W-1:0]   white_level_o;
  logic                degenerate_o;

  calib_scoreboard sb;
  int              cycles     = 0;
  int              items_sent = 0;
  bit              tx_calm    = 1'b0;   // sender runs back to back while set
  bit              rx_calm    = 1'b0;   // receiver pops every cycle while set
  // per-epoch ceilings for sample readings; reshuffled at every random clear
  int              black_cap  = 1500;
  int              white_cap  = 4095;

  line_sensor_calibrate_normalize_unit #(
    .CHANNELS      (CHANNELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .command_i     (command_i),
    .channel_i     (channel_i),
    .adc_high_i    (adc_high_i),
    .adc_low_i     (adc_low_i),
    .empty         (empty),
    .pop           (pop),
    .out_channel_o (out_channel_o),
    .reading_o     (reading_o),
    .level_o       (level_o),
    .black_level_o (black_level_o),
    .white_level_o (white_level_o),
    .degenerate_o  (degenerate_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycles, sb.outstanding());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long hole.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One input transaction. Called at a rising edge; returns at the edge that took it.
  // Fields and push change only at rising edges, and push gets one assignment per edge.
  task automatic send_item(cmd_e cmd, logic [CHAN_W-1:0] ch,
                           logic [ADC_W-1:0] hi, logic [ADC_W-1:0] lo);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    command_i  <= cmd;
    channel_i  <= ch;
    adc_high_i <= hi;
    adc_low_i  <= lo;
    do @(posedge clk_i); while (full);
    sb.note_input(cmd, ch, hi, lo);
    items_sent++;
    if (items_sent % 97 == 0) tx_calm = ~tx_calm;
  endtask

  // Build the two ADC bytes for a 12-bit reading; the unused top nibble is random.
  task automatic send_reading(cmd_e cmd, logic [CHAN_W-1:0] ch, int unsigned rd);
    logic [ADC_W-1:0] hi;
    hi = {4'($urandom), 4'(rd >> 8)};
    send_item(cmd, ch, hi, 8'(rd));
  endtask

  // Hold the sender until every predicted result has been popped.
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Result side: random pop stalls, checks each popped transaction.
  task automatic collect_results();
    int      stall;
    int      popped;
    result_t got;
    popped = 0;
    forever begin
      stall = pick_gap(rx_calm);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.out_channel = out_channel_o;
      got.reading     = reading_o;
      got.level       = level_o;
      got.black_level = black_level_o;
      got.white_level = white_level_o;
      got.degenerate  = degenerate_o;
      sb.check_result(got);
      popped++;
      if (popped % 83 == 0) rx_calm = ~rx_calm;
    end
  endtask

  // Random reading for a normalize: anywhere, or hugging the stored black/white edges
  // where the clamps and the first/last quotient steps live.
  function automatic int unsigned norm_reading(logic [CHAN_W-1:0] ch);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 4095);
    if (r < 7) v = int'(sb.cal_black[ch]) + $urandom_range(0, 4) - 2;
    else       v = int'(sb.cal_white[ch]) + $urandom_range(0, 4) - 2;
    if (v < 0)    v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic random_traffic();
    int                r;
    logic [CHAN_W-1:0] ch;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // drain fully twice so the back end sees a cold restart mid-run
      if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3) wait_idle();
      ch = 4'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 2) begin
        black_cap = $urandom_range(0, 4095);
        white_cap = $urandom_range(0, 4095);
        send_item(CMD_CLEAR, ch, 8'($urandom), 8'($urandom));
      end else if (r < 22) begin
        send_reading(CMD_BLACK, ch, $urandom_range(0, black_cap));
      end else if (r < 42) begin
        send_reading(CMD_WHITE, ch, $urandom_range(0, white_cap));
      end else if (r < 46) begin
        // raw noise: any bytes, any command but clear
        send_item(cmd_e'($urandom_range(1, 3)), ch, 8'($urandom), 8'($urandom));
      end else begin
        send_reading(CMD_NORM, ch, norm_reading(ch));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      collect_results();
    join_none

    // Directed: fresh stores, clamps, exact edges, white below black, full scale.
    send_item(CMD_CLEAR, 4'd0, 8'hFF, 8'hFF);
    send_item(CMD_NORM,  4'd0, 8'h00, 8'h00);     // zero span, reading at black
    send_item(CMD_NORM,  4'd0, 8'hF0, 8'h01);     // zero span, reading above black
    send_reading(CMD_BLACK, 4'd15, 256);
    send_item(CMD_BLACK, 4'd15, 8'hA0, 8'h80);    // lower sample, max holds
    send_reading(CMD_WHITE, 4'd15, 3840);
    send_reading(CMD_NORM,  4'd15, 0);            // below black
    send_reading(CMD_NORM,  4'd15, 256);          // at black
    send_reading(CMD_NORM,  4'd15, 257);
    send_reading(CMD_NORM,  4'd15, 2048);
    send_reading(CMD_NORM,  4'd15, 3839);
    send_reading(CMD_NORM,  4'd15, 3840);         // at white
    send_item(CMD_NORM,  4'd15, 8'hFF, 8'hFF);    // above white, all ones
    send_reading(CMD_BLACK, 4'd3, 2000);
    send_reading(CMD_WHITE, 4'd3, 1000);          // white under black
    send_reading(CMD_NORM,  4'd3, 2000);
    send_reading(CMD_NORM,  4'd3, 2001);
    send_reading(CMD_WHITE, 4'd3, 2000);          // white equal to black
    send_reading(CMD_NORM,  4'd3, 3000);
    send_item(CMD_WHITE, 4'd7, 8'h0F, 8'hFF);     // widest span
    send_reading(CMD_NORM,  4'd7, 4094);
    send_reading(CMD_NORM,  4'd7, 1);
    send_item(CMD_CLEAR, 4'd9, 8'h00, 8'h00);
    send_reading(CMD_NORM,  4'd15, 100);          // cleared channel again degenerate
    wait_idle();

    random_traffic();

    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d input transactions, checked %0d results (%0d normalize, %0d degenerate).",
             items_sent, sb.results_checked, sb.norm_count, sb.degen_count);
    $display("Left over: %0d expected results, %0d mismatches.",
             sb.outstanding(), sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
